// File: rtl/tree_depth_nearest_marked_node_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef TREE_DEPTH_NEAREST_MARKED_NODE_ASSERT_SVH
`define TREE_DEPTH_NEAREST_MARKED_NODE_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define TDN_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked while reset is high.
`define TDN_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/tdn_pkg.sv
`default_nettype none
package tdn_pkg;

   localparam int MAX_NODES  = 1024;
   localparam int SLOT_CAP   = 2 * MAX_NODES;
   localparam int NODE_W     = 11;
   localparam int DEPTH_W    = 10;
   localparam int SLOT_W     = 12;
   localparam int NODE_IDX_W = $clog2(MAX_NODES);
   localparam int SLOT_IDX_W = $clog2(SLOT_CAP);
   localparam int SP_W       = NODE_IDX_W + 1;

   localparam logic [SLOT_W-1:0]  NIL_SLOT  = '1;
   localparam logic [NODE_W-1:0]  NONE_VAL  = '1;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

   // Request action codes.
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_EDGE  = 2'd1;
   localparam logic [1:0] ACT_WALK  = 2'd2;
   localparam logic [1:0] ACT_CAND  = 2'd3;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CLR_SWEEP,
      OP_WALK_SWEEP,
      OP_E_RDA,
      OP_E_WRA,
      OP_E_RDB,
      OP_E_WRB,
      OP_W_HEAD1,
      OP_W_START,
      OP_W_SLOT,
      OP_W_POP,
      OP_W_NB,
      OP_W_VIS,
      OP_W_PUSH,
      OP_C_CMP
   } dp_op_type;

   // Status the datapath reports back to the controller.
   typedef struct packed {
      logic sweep_last;
      logic edge_ok;
      logic top_nil;
      logic sp_one;
      logic nb_visited;
      logic rsp_busy;
   } dp_stat_type;

   // One entry of the walk stack.
   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [DEPTH_W-1:0] depth;
   } stk_entry_type;

endpackage
`default_nettype wire

// File: rtl/tree_depth_nearest_marked_node.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_action, req_node_a, req_node_b
// rsp       out        rsp_valid/rsp_ready    rsp_best_node, rsp_best_depth
// csr       in         csr_valid/csr_ready    csr_node_count
//
// One request is worked at a time. Clear is a sweep of the 1024-entry node
// memory; traverse is such a sweep, then the walk on the slot and stack memories.
// An edge makes two list appends, a candidate one compare.
// After reset a clearing pass runs with req_ready low.
// A waiting response stalls only the candidate that would replace it.
module tree_depth_nearest_marked_node (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_action,
   input  wire logic [tdn_pkg::NODE_W-1:0]  req_node_a,
   input  wire logic [tdn_pkg::NODE_W-1:0]  req_node_b,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [tdn_pkg::NODE_W-1:0]       rsp_best_node,
   output logic [tdn_pkg::DEPTH_W-1:0]      rsp_best_depth,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [tdn_pkg::NODE_W-1:0]  csr_node_count
);

   tdn_pkg::dp_op_type   op;
   tdn_pkg::dp_stat_type stat;

   // Sequencer.
   tdn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .stat       (stat),
      .op         (op)
   );

   // Memories and registers.
   tdn_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .stat           (stat),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_node_count (csr_node_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_best_node  (rsp_best_node),
      .rsp_best_depth (rsp_best_depth)
   );

endmodule
`default_nettype wire

// File: rtl/tdn_ctrl.sv
`default_nettype none
module tdn_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_action,
   output logic                   req_ready,
   input  wire tdn_pkg::dp_stat_type stat,
   output tdn_pkg::dp_op_type     op
);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_E_RDA, S_E_WRA, S_E_RDB, S_E_WRB,
      S_W_SWEEP, S_W_HEAD1, S_W_START, S_W_SLOT, S_W_POP, S_W_NB,
      S_W_VIS, S_W_PUSH, S_C_RD, S_C_CMP
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and the operation for this cycle.
   always_comb begin
      state_in = state_ff;
      op       = tdn_pkg::OP_NONE;
      case (state_ff)
         S_CLR: begin
            op = tdn_pkg::OP_CLR_SWEEP;
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               op = tdn_pkg::OP_ACCEPT;
               case (req_action)
                  tdn_pkg::ACT_CLEAR: state_in = S_CLR;
                  tdn_pkg::ACT_EDGE:  state_in = S_E_RDA;
                  tdn_pkg::ACT_WALK:  state_in = S_W_SWEEP;
                  default:            state_in = S_C_RD;
               endcase
            end
         end
         S_E_RDA: begin
            if (stat.edge_ok) begin
               op       = tdn_pkg::OP_E_RDA;
               state_in = S_E_WRA;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_E_WRA: begin
            op       = tdn_pkg::OP_E_WRA;
            state_in = S_E_RDB;
         end
         S_E_RDB: begin
            op       = tdn_pkg::OP_E_RDB;
            state_in = S_E_WRB;
         end
         S_E_WRB: begin
            op       = tdn_pkg::OP_E_WRB;
            state_in = S_IDLE;
         end
         S_W_SWEEP: begin
            op = tdn_pkg::OP_WALK_SWEEP;
            if (stat.sweep_last) state_in = S_W_HEAD1;
         end
         S_W_HEAD1: begin
            op       = tdn_pkg::OP_W_HEAD1;
            state_in = S_W_START;
         end
         S_W_START: begin
            op       = tdn_pkg::OP_W_START;
            state_in = S_W_SLOT;
         end
         S_W_SLOT: begin
            op = tdn_pkg::OP_W_SLOT;
            if (!stat.top_nil) state_in = S_W_NB;
            else if (stat.sp_one) state_in = S_IDLE;
            else state_in = S_W_POP;
         end
         S_W_POP: begin
            op       = tdn_pkg::OP_W_POP;
            state_in = S_W_SLOT;
         end
         S_W_NB: begin
            op       = tdn_pkg::OP_W_NB;
            state_in = S_W_VIS;
         end
         S_W_VIS: begin
            op       = tdn_pkg::OP_W_VIS;
            state_in = stat.nb_visited ? S_W_SLOT : S_W_PUSH;
         end
         S_W_PUSH: begin
            op       = tdn_pkg::OP_W_PUSH;
            state_in = S_W_SLOT;
         end
         S_C_RD: begin
            state_in = S_C_CMP;
         end
         S_C_CMP: begin
            if (!stat.rsp_busy) begin
               op       = tdn_pkg::OP_C_CMP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register; reset starts with a clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/tdn_dpath.sv
`default_nettype none
module tdn_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tdn_pkg::dp_op_type          op,
   output tdn_pkg::dp_stat_type             stat,
   input  wire logic [tdn_pkg::NODE_W-1:0]  req_node_a,
   input  wire logic [tdn_pkg::NODE_W-1:0]  req_node_b,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [tdn_pkg::NODE_W-1:0]  csr_node_count,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [tdn_pkg::NODE_W-1:0]       rsp_best_node,
   output logic [tdn_pkg::DEPTH_W-1:0]      rsp_best_depth
);

   localparam int NW = tdn_pkg::NODE_W;
   localparam int DW = tdn_pkg::DEPTH_W;
   localparam int SW = tdn_pkg::SLOT_W;
   localparam int NI = tdn_pkg::NODE_IDX_W;
   localparam int SI = tdn_pkg::SLOT_IDX_W;
   localparam int PW = tdn_pkg::SP_W;
   localparam int IW = DW + 1;

   // Memories.
   logic [SW-1:0]                 head_mem [tdn_pkg::MAX_NODES];
   logic [SW-1:0]                 tail_mem [tdn_pkg::MAX_NODES];
   logic [IW-1:0]                 info_mem [tdn_pkg::MAX_NODES];
   logic [SW-1:0]                 next_mem [tdn_pkg::SLOT_CAP];
   logic [NW-1:0]                 nbr_mem  [tdn_pkg::SLOT_CAP];
   tdn_pkg::stk_entry_type        stk_mem  [tdn_pkg::MAX_NODES];

   logic [SW-1:0] head_rd_ff, tail_rd_ff, next_rd_ff;
   logic [NW-1:0] nbr_rd_ff;
   logic [IW-1:0] info_rd_ff;
   tdn_pkg::stk_entry_type stk_rd_ff;

   logic          head_we, tail_we, info_we, next_we, nbr_we, stk_we, info_re;
   logic [NI-1:0] head_wa, head_ra, info_wa, info_ra, stk_wa, stk_ra;
   logic [SW-1:0] head_wd;
   logic [IW-1:0] info_wd;
   logic [SI-1:0] next_wa, nbr_wa;
   logic [SW-1:0] next_wd;
   logic [NW-1:0] nbr_wd;

   // Registers.
   logic [NW-1:0] count_ff, a_ff, b_ff, nb_ff, ch_node_ff, ch_depth_ff;
   logic [SW-1:0] slots_ff, top_slot_ff;
   logic [DW-1:0] top_depth_ff, dnew_ff;
   logic [PW-1:0] sp_ff;
   logic [NI-1:0] sweep_ff;
   logic          rsp_valid_ff;
   logic [NW-1:0] rsp_node_ff;
   logic [DW-1:0] rsp_depth_ff;

   logic [NW-1:0] cnt, ch_node_in, ch_depth_in;
   logic          a_ok, b_ok, better;
   logic [SW-1:0] s_cur;
   logic [DW-1:0] dnew;

   assign csr_ready = 1'b1;

   // Node count saturated into the legal range.
   always_comb begin
      cnt = count_ff;
      if (count_ff == '0) cnt = NW'(1);
      else if (count_ff > NW'(tdn_pkg::MAX_NODES)) cnt = NW'(tdn_pkg::MAX_NODES);
   end

   assign a_ok  = (a_ff != '0) && (a_ff <= cnt);
   assign b_ok  = (b_ff != '0) && (b_ff <= cnt);
   assign s_cur = (op == tdn_pkg::OP_E_RDB || op == tdn_pkg::OP_E_WRB) ?
                  slots_ff + SW'(1) : slots_ff;
   assign dnew  = (top_depth_ff == tdn_pkg::DEPTH_MAX) ? top_depth_ff
                                                       : top_depth_ff + DW'(1);

   // Candidate ordering: shallower first, then smaller id.
   assign better = a_ok && ((NW'(info_rd_ff[DW-1:0]) < ch_depth_ff) ||
                  ((NW'(info_rd_ff[DW-1:0]) == ch_depth_ff) && (a_ff < ch_node_ff)));
   assign ch_node_in  = better ? a_ff : ch_node_ff;
   assign ch_depth_in = better ? NW'(info_rd_ff[DW-1:0]) : ch_depth_ff;

   // Status to the controller.
   always_comb begin
      stat.sweep_last = (sweep_ff == '1);
      stat.edge_ok    = a_ok && b_ok &&
                        (slots_ff <= SW'(tdn_pkg::SLOT_CAP - 2));
      stat.top_nil    = top_slot_ff[SW-1];
      stat.sp_one     = (sp_ff == PW'(1));
      stat.nb_visited = info_rd_ff[DW];
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // Memory port steering for each operation.
   always_comb begin
      head_we = 1'b0; head_wa = a_ff[NI-1:0]; head_wd = s_cur;
      head_ra = a_ff[NI-1:0];
      tail_we = 1'b0;
      info_we = 1'b0; info_wa = sweep_ff; info_wd = '0;
      info_re = 1'b0; info_ra = a_ff[NI-1:0];
      next_we = 1'b0; next_wa = s_cur[SI-1:0]; next_wd = tdn_pkg::NIL_SLOT;
      nbr_we  = 1'b0; nbr_wa  = s_cur[SI-1:0]; nbr_wd  = b_ff;
      stk_we  = 1'b0; stk_wa  = NI'(sp_ff - PW'(1));
      stk_ra  = NI'(sp_ff - PW'(2));
      case (op)
         tdn_pkg::OP_ACCEPT: begin
            info_re = 1'b1;
            info_ra = req_node_a[NI-1:0];
         end
         tdn_pkg::OP_CLR_SWEEP: begin
            head_we = 1'b1; head_wa = sweep_ff; head_wd = tdn_pkg::NIL_SLOT;
            info_we = 1'b1;
         end
         tdn_pkg::OP_WALK_SWEEP: info_we = 1'b1;
         tdn_pkg::OP_E_RDA: begin
            nbr_we = 1'b1; next_we = 1'b1;
         end
         tdn_pkg::OP_E_WRA: begin
            head_we = head_rd_ff[SW-1];
            tail_we = 1'b1;
            next_we = !head_rd_ff[SW-1];
            next_wa = tail_rd_ff[SI-1:0];
            next_wd = s_cur;
         end
         tdn_pkg::OP_E_RDB: begin
            nbr_we = 1'b1; nbr_wd = a_ff; next_we = 1'b1;
            head_ra = b_ff[NI-1:0];
         end
         tdn_pkg::OP_E_WRB: begin
            head_wa = b_ff[NI-1:0];
            head_ra = b_ff[NI-1:0];
            head_we = head_rd_ff[SW-1];
            tail_we = 1'b1;
            next_we = !head_rd_ff[SW-1];
            next_wa = tail_rd_ff[SI-1:0];
            next_wd = s_cur;
         end
         tdn_pkg::OP_W_HEAD1: head_ra = NI'(1);
         tdn_pkg::OP_W_START: begin
            info_we = 1'b1; info_wa = NI'(1); info_wd = {1'b1, DW'(0)};
         end
         tdn_pkg::OP_W_NB: begin
            info_re = 1'b1; info_ra = nbr_rd_ff[NI-1:0];
         end
         tdn_pkg::OP_W_VIS: begin
            head_ra = nb_ff[NI-1:0];
            info_we = !info_rd_ff[DW];
            info_wa = nb_ff[NI-1:0];
            info_wd = {1'b1, dnew};
            stk_we  = !info_rd_ff[DW];
         end
         default: ;
      endcase
   end

   // Node memories.
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      head_rd_ff <= head_mem[head_ra];
      if (tail_we) tail_mem[head_wa] <= s_cur;
      tail_rd_ff <= tail_mem[head_ra];
      if (info_we) info_mem[info_wa] <= info_wd;
      if (info_re) info_rd_ff <= info_mem[info_ra];
   end

   // Slot memories, read at the current top slot.
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      next_rd_ff <= next_mem[top_slot_ff[SI-1:0]];
      if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
      nbr_rd_ff <= nbr_mem[top_slot_ff[SI-1:0]];
   end

   // Walk stack; entries below the top, the top lives in registers.
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= '{slot: top_slot_ff, depth: top_depth_ff};
      stk_rd_ff <= stk_mem[stk_ra];
   end

   // Request fields and walk registers.
   always_ff @(posedge clock) begin
      if (op == tdn_pkg::OP_ACCEPT) begin
         a_ff <= req_node_a;
         b_ff <= req_node_b;
      end
      case (op)
         tdn_pkg::OP_W_START: begin
            top_slot_ff <= head_rd_ff; top_depth_ff <= '0;
         end
         tdn_pkg::OP_W_POP: begin
            top_slot_ff <= stk_rd_ff.slot; top_depth_ff <= stk_rd_ff.depth;
         end
         tdn_pkg::OP_W_NB: begin
            nb_ff <= nbr_rd_ff; top_slot_ff <= next_rd_ff;
         end
         tdn_pkg::OP_W_VIS: dnew_ff <= dnew;
         tdn_pkg::OP_W_PUSH: begin
            top_slot_ff <= head_rd_ff; top_depth_ff <= dnew_ff;
         end
         default: ;
      endcase
      if (op == tdn_pkg::OP_C_CMP) begin
         rsp_node_ff  <= (ch_node_in == tdn_pkg::NONE_VAL) ? '0 : ch_node_in;
         rsp_depth_ff <= (ch_node_in == tdn_pkg::NONE_VAL) ? '0 : ch_depth_in[DW-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= NW'(tdn_pkg::MAX_NODES);
         slots_ff     <= '0;
         sweep_ff     <= '0;
         sp_ff        <= '0;
         ch_node_ff   <= tdn_pkg::NONE_VAL;
         ch_depth_ff  <= tdn_pkg::NONE_VAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) count_ff <= csr_node_count;
         if (op == tdn_pkg::OP_CLR_SWEEP || op == tdn_pkg::OP_WALK_SWEEP) begin
            sweep_ff <= sweep_ff + NI'(1);
         end
         if (op == tdn_pkg::OP_CLR_SWEEP) begin
            slots_ff    <= '0;
            ch_node_ff  <= tdn_pkg::NONE_VAL;
            ch_depth_ff <= tdn_pkg::NONE_VAL;
         end
         if (op == tdn_pkg::OP_E_WRB) slots_ff <= slots_ff + SW'(2);
         case (op)
            tdn_pkg::OP_W_START: sp_ff <= PW'(1);
            tdn_pkg::OP_W_POP:   sp_ff <= sp_ff - PW'(1);
            tdn_pkg::OP_W_PUSH:  sp_ff <= sp_ff + PW'(1);
            default: ;
         endcase
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (op == tdn_pkg::OP_C_CMP) begin
            ch_node_ff   <= ch_node_in;
            ch_depth_ff  <= ch_depth_in;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_node  = rsp_node_ff;
   assign rsp_best_depth = rsp_depth_ff;

endmodule
`default_nettype wire

// File: rtl/tdn_check.sv
`default_nettype none
`include "tree_depth_nearest_marked_node_assert.svh"
module tdn_check (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [tdn_pkg::NODE_W-1:0]  rsp_best_node,
   input wire logic [tdn_pkg::DEPTH_W-1:0] rsp_best_depth
);

   // A response with no best node carries depth zero.
   `TDN_ASSERT_IMP(a_none_depth, clock, reset, rsp_valid && rsp_best_node == '0, rsp_best_depth == '0)

   // Right after reset the clearing pass blocks requests and no response shows.
   `TDN_ASSERT_IMP(a_reset_idle, clock, reset, $past(reset), !req_ready && !rsp_valid)

   // A stalled response stays.
   `TDN_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled response keeps its payload.
   `TDN_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_best_node) && $stable(rsp_best_depth))

endmodule

bind tree_depth_nearest_marked_node tdn_check u_tdn_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_best_node  (rsp_best_node),
   .rsp_best_depth (rsp_best_depth)
);
`default_nettype wire
